@@ rtl/bbma_pkg.sv @@
// Package for the bounded byte memory access block: command codes, sizes and
// the check result type shared by the bounds checker and the top level.
// Depends on nothing.
package bbma_pkg;

  localparam int ADDR_W        = 64;
  localparam int DATA_W        = 64;
  localparam int BANKS         = 8;
  localparam int BYTE_W        = 8;
  localparam int DEF_MEM_BYTES = 65536;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STORE   = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [1:0] SIZE_1 = 2'd0;
  localparam logic [1:0] SIZE_2 = 2'd1;
  localparam logic [1:0] SIZE_4 = 2'd2;
  localparam logic [1:0] SIZE_8 = 2'd3;

  // Result of the address checks, valid in the access cycle.
  typedef struct packed {
    logic fault;      // access leaves main memory or wraps
    logic in_window;  // address lies in the 8-byte window above the reserved address
  } chk_res_t;

  // Access length minus one, as a byte index limit.
  function automatic logic [2:0] size_last(input logic [1:0] size_code);
    logic [2:0] last;
    case (size_code)
      SIZE_1:  last = 3'd0;
      SIZE_2:  last = 3'd1;
      SIZE_4:  last = 3'd3;
      SIZE_8:  last = 3'd7;
      default: last = 3'd0;
    endcase
    return last;
  endfunction

endpackage

@@ rtl/bbma_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module bbma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bbma_bounds.sv @@
// Two-stage address checker: subtractions are registered in the first stage,
// the compares against the memory size and the window follow in the second.
// Depends on bbma_pkg.
module bbma_bounds
  import bbma_pkg::*;
#(
  parameter int MEM_BYTES = DEF_MEM_BYTES,
  parameter int OFF_W     = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [1:0]        size_code,
  input  logic [ADDR_W-1:0] base,
  input  logic [ADDR_W-1:0] res_addr,
  output logic [OFF_W-1:0]  off,
  output chk_res_t          chk
);

  localparam logic [ADDR_W-1:0] MemSize = ADDR_W'(MEM_BYTES);

  logic [ADDR_W-1:0] off_r, off_nxt;
  logic              below_r, below_nxt;
  logic              wrap_r, wrap_nxt;
  logic              rbelow_r, rbelow_nxt;
  logic              rnear_r, rnear_nxt;
  logic [ADDR_W-1:0] rdiff;
  logic [3:0]        tail;
  logic [3:0]        len;

  always_comb begin
    {below_nxt, off_nxt} = {1'b0, addr} - {1'b0, base};
    {rbelow_nxt, rdiff}  = {1'b0, addr} - {1'b0, res_addr};
    rnear_nxt            = (rdiff[ADDR_W-1:3] == '0);
    // The last byte lies past the top of the address space.
    tail     = {1'b0, addr[2:0]} + {1'b0, size_last(size_code)};
    wrap_nxt = (&addr[ADDR_W-1:3]) && tail[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r    <= off_nxt;
      below_r  <= below_nxt;
      wrap_r   <= wrap_nxt;
      rbelow_r <= rbelow_nxt;
      rnear_r  <= rnear_nxt;
    end
  end

  always_comb begin
    len           = {1'b0, size_last(size_code)} + 4'd1;
    chk.fault     = below_r || wrap_r || (off_r > (MemSize - {{(ADDR_W-4){1'b0}}, len}));
    chk.in_window = !rbelow_r && rnear_r;
  end

  assign off = off_r[OFF_W-1:0];

endmodule

@@ rtl/bounded_byte_memory_access.sv @@
// Top level of the bounded byte memory access block: command sequencer,
// eight byte-wide memory banks, reservation register and result assembly.
// Depends on bbma_pkg, bbma_ram and bbma_bounds.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   command  | in_cmd, in_access_address, in_size_code, | start && !busy
//            | in_store_data                           |
//   result   | out_load_data, out_access_fault,        | out_valid, one cycle
//            | out_reservation_held                    |
//   config   | cfg_wdata                               | cfg_we
//
// A transaction moves from the accepting edge through S_CALC for the address
// subtractions, S_ACCESS for the compares and the bank access, and S_RESP for
// the registered bank read, in which the result is shown; a new command is taken
// only back in S_IDLE, so a command is not accepted before the last is through.
// After reset the banks are zeroed one row per cycle, MEM_BYTES/8 rows
// (rounded up), while busy stays high; cfg_we is honored during that time.
// The result receiver cannot stall, so nothing back-pressures the sequencer.
module bounded_byte_memory_access
  import bbma_pkg::*;
#(
  parameter int MEM_BYTES = DEF_MEM_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [ADDR_W-1:0] in_access_address,
  input  logic [1:0]        in_size_code,
  input  logic [DATA_W-1:0] in_store_data,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_load_data,
  output logic              out_access_fault,
  output logic              out_reservation_held,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  localparam int ROWS  = (MEM_BYTES + BANKS - 1) / BANKS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OFF_W = RW + 3;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_ACCESS = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [RW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [1:0]        size_r;
  logic [DATA_W-1:0] data_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              res_valid_r, res_valid_nxt;

  logic              accept;
  logic              clearing;
  logic [OFF_W-1:0]  off;
  chk_res_t          chk;
  logic [2:0]        lo;
  logic [2:0]        last;
  logic [RW-1:0]     row;
  logic              store_go;
  logic              load_ok;

  logic              bank_we    [BANKS];
  logic [RW-1:0]     bank_addr  [BANKS];
  logic [BYTE_W-1:0] bank_wdata [BANKS];
  logic [BYTE_W-1:0] bank_rdata [BANKS];

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + RW'(1);
        if (clr_cnt_r == RW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC:   state_nxt = S_ACCESS;
      S_ACCESS: state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // The window check is made before the bounds, so a faulting store still clears it.
  always_comb begin
    res_addr_nxt  = res_addr_r;
    res_valid_nxt = res_valid_r;
    if (state_r == S_ACCESS) begin
      if (cmd_r == CMD_STORE && res_valid_r && chk.in_window) begin
        res_addr_nxt  = '0;
        res_valid_nxt = 1'b0;
      end else if (cmd_r == CMD_RESERVE) begin
        res_addr_nxt  = addr_r;
        res_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      base_r      <= '0;
      res_addr_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      res_addr_r  <= res_addr_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      addr_r <= in_access_address;
      size_r <= in_size_code;
      data_r <= in_store_data;
    end
  end

  bbma_bounds #(
    .MEM_BYTES (MEM_BYTES),
    .OFF_W     (OFF_W)
  ) u_bounds (
    .clk       (clk),
    .en        (state_r == S_CALC),
    .addr      (addr_r),
    .size_code (size_r),
    .base      (base_r),
    .res_addr  (res_addr_r),
    .off       (off),
    .chk       (chk)
  );

  assign lo       = off[2:0];
  assign row      = off[OFF_W-1:3];
  assign last     = size_last(size_r);
  assign store_go = (state_r == S_ACCESS) && (cmd_r == CMD_STORE) && !chk.fault;
  assign load_ok  = (cmd_r == CMD_LOAD) && !chk.fault;

  // Bank b holds byte (b - lo) of the access; banks below lo wrap to the next row.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [2:0] idx;
    assign idx = 3'(b) - lo;

    always_comb begin
      if (clearing) begin
        bank_we[b]    = 1'b1;
        bank_addr[b]  = clr_cnt_r;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = store_go && (idx <= last);
        bank_addr[b]  = row + RW'(3'(b) < lo);
        bank_wdata[b] = data_r[{idx, 3'b000} +: BYTE_W];
      end
    end

    bbma_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS),
      .AW    (RW)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .addr  (bank_addr[b]),
      .wdata (bank_wdata[b]),
      .rdata (bank_rdata[b])
    );
  end

  always_comb begin
    out_load_data = '0;
    for (int i = 0; i < BANKS; i++) begin
      if (load_ok && (3'(i) <= last)) begin
        out_load_data[i*BYTE_W +: BYTE_W] = bank_rdata[3'(i) + lo];
      end
    end
  end

  assign out_valid            = (state_r == S_RESP);
  assign out_access_fault     = chk.fault && ((cmd_r == CMD_LOAD) || (cmd_r == CMD_STORE));
  assign out_reservation_held = res_valid_r;

  a_resp_follows_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_ACCESS)
    else $error("result strobe without a preceding bank access");

  a_fault_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_access_fault) |-> (out_load_data == '0))
    else $error("faulting transaction returned nonzero data");

  a_reserve_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r == CMD_RESERVE) |-> out_reservation_held)
    else $error("reserve transaction did not leave the reservation valid");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CALC))
    else $error("accepted transaction did not enter the address stage");

  a_no_write_while_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !bank_we[0])
    else $error("bank written while no transaction is active");

endmodule

@@ tb/bounded_byte_memory_access_tb.sv @@
// Testbench for bounded_byte_memory_access: directed and random load, store and reserve
// transactions, each result checked against an in-bench memory and reservation model.
// Depends on bbma_pkg and the bounded_byte_memory_access RTL.
module bounded_byte_memory_access_tb;
  import bbma_pkg::*;

  localparam int MEM_SIZE      = DEF_MEM_BYTES;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  typedef struct packed {
    logic [DATA_W-1:0] load_data;
    logic              fault;
    logic              held;
  } access_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_NOP;
  logic [ADDR_W-1:0] in_access_address = '0;
  logic [1:0]        in_size_code = SIZE_1;
  logic [DATA_W-1:0] in_store_data = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_load_data;
  logic              out_access_fault;
  logic              out_reservation_held;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  // Model of the block: memory image, base register and reservation.
  logic [7:0]        mem_image [MEM_SIZE];
  logic [ADDR_W-1:0] model_base = '0;
  logic [ADDR_W-1:0] resv_addr = '0;
  logic              resv_valid = 1'b0;

  access_result_t expected_results[$];
  access_result_t due_result;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  bit             gaps_enabled = 1'b1;

  bounded_byte_memory_access #(.MEM_BYTES(MEM_SIZE)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_access_address   (in_access_address),
    .in_size_code        (in_size_code),
    .in_store_data       (in_store_data),
    .out_valid           (out_valid),
    .out_load_data       (out_load_data),
    .out_access_fault    (out_access_fault),
    .out_reservation_held(out_reservation_held),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: actual data %h fault %b held %b",
                 $time, out_load_data, out_access_fault, out_reservation_held);
        mismatch_count++;
      end else begin
        due_result = expected_results.pop_front();
        if (out_load_data !== due_result.load_data) begin
          $display("%0t: load_data expected %h actual %h",
                   $time, due_result.load_data, out_load_data);
          mismatch_count++;
        end
        if (out_access_fault !== due_result.fault) begin
          $display("%0t: access_fault expected %b actual %b",
                   $time, due_result.fault, out_access_fault);
          mismatch_count++;
        end
        if (out_reservation_held !== due_result.held) begin
          $display("%0t: reservation_held expected %b actual %b",
                   $time, due_result.held, out_reservation_held);
          mismatch_count++;
        end
      end
    end
  end

  // Applies one accepted transaction to the model and queues its result.
  task automatic predict_access(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                                input logic [1:0] size, input logic [DATA_W-1:0] data);
    access_result_t res;
    logic [ADDR_W:0]   end_excl;
    logic [ADDR_W-1:0] offset;
    int                nbytes;
    logic              in_range;
    nbytes   = 1 << size;
    end_excl = {1'b0, addr} + nbytes;
    offset   = addr - model_base;
    in_range = (addr >= model_base) && (end_excl <= {1'b1, {ADDR_W{1'b0}}}) &&
               ({1'b0, offset} + nbytes <= MEM_SIZE);
    res = '0;
    case (cmd)
      CMD_LOAD: begin
        if (in_range) begin
          for (int i = 0; i < nbytes; i++)
            res.load_data[8*i +: 8] = mem_image[int'(offset) + i];
        end else begin
          res.fault = 1'b1;
        end
      end
      CMD_STORE: begin
        // The window test comes before the bounds, so a faulting store still clears it.
        if (resv_valid && addr >= resv_addr && (addr - resv_addr) < 8) begin
          resv_valid = 1'b0;
          resv_addr  = '0;
        end
        if (in_range) begin
          for (int i = 0; i < nbytes; i++)
            mem_image[int'(offset) + i] = data[8*i +: 8];
        end else begin
          res.fault = 1'b1;
        end
      end
      CMD_RESERVE: begin
        resv_addr  = addr;
        resv_valid = 1'b1;
      end
      default: ;
    endcase
    res.held = resv_valid;
    expected_results.push_back(res);
  endtask

  // Start is left high after acceptance; the next call decides in the same step
  // whether to drop it for an idle gap or to present the next command.
  task automatic send_access(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [1:0] size, input logic [DATA_W-1:0] data);
    while (gaps_enabled && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_cmd            <= cmd;
    in_access_address <= addr;
    in_size_code      <= size;
    in_store_data     <= data;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_access(cmd, addr, size, data);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_base = value;
  endtask

  // Memory is cleared at reset, so every in-range load reads zero here.
  task automatic test_reset_state();
    write_base('0);
    send_access(CMD_LOAD, 64'd0, SIZE_8, '0);
    send_access(CMD_LOAD, 64'(MEM_SIZE - 8), SIZE_8, '0);
    send_access(CMD_LOAD, 64'(MEM_SIZE - 1), SIZE_2, '0);
  endtask

  task automatic test_sizes();
    logic [ADDR_W-1:0] base;
    base = 64'h0000_1000_0000_0000;
    write_base(base);
    send_access(CMD_STORE, base, SIZE_8, 64'h8877_6655_4433_2211);
    send_access(CMD_LOAD, base + 1, SIZE_1, '0);
    send_access(CMD_LOAD, base + 2, SIZE_2, '0);
    send_access(CMD_LOAD, base + 4, SIZE_4, '0);
    send_access(CMD_STORE, base + 3, SIZE_1, ALL_ONES);
    send_access(CMD_LOAD, base, SIZE_8, '0);
  endtask

  task automatic test_bounds();
    send_access(CMD_LOAD, model_base - 1, SIZE_1, '0);
    send_access(CMD_STORE, model_base + MEM_SIZE - 4, SIZE_8, ALL_ONES);
    send_access(CMD_LOAD, model_base + MEM_SIZE - 8, SIZE_8, '0);
    send_access(CMD_LOAD, ALL_ONES, SIZE_1, '0);
  endtask

  // Memory ending exactly at the top of the address space, then a one-byte memory window.
  task automatic test_top_of_space();
    write_base(ALL_ONES - MEM_SIZE + 1);
    send_access(CMD_STORE, ALL_ONES - 7, SIZE_8, 64'hdead_beef_0bad_f00d);
    send_access(CMD_LOAD, ALL_ONES, SIZE_1, '0);
    send_access(CMD_LOAD, ALL_ONES, SIZE_2, '0);
    write_base(ALL_ONES);
    send_access(CMD_LOAD, ALL_ONES, SIZE_1, '0);
    send_access(CMD_LOAD, ALL_ONES, SIZE_4, '0);
  endtask

  task automatic test_reservation();
    write_base('0);
    send_access(CMD_RESERVE, 64'h100, SIZE_8, ALL_ONES);
    send_access(CMD_STORE, 64'h108, SIZE_1, 64'h5a);
    send_access(CMD_STORE, 64'h0ff, SIZE_8, 64'h0123_4567_89ab_cdef);
    send_access(CMD_STORE, 64'h107, SIZE_2, 64'ha5a5);
    send_access(CMD_RESERVE, ALL_ONES - 3, SIZE_1, '0);
    send_access(CMD_STORE, ALL_ONES, SIZE_1, 64'h77);
    send_access(CMD_RESERVE, 64'h40, SIZE_4, '0);
    send_access(CMD_NOP, 64'h40, SIZE_8, ALL_ONES);
  endtask

  // Two picks in five land in a small hot region so loads see earlier stores.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      return model_base + $urandom_range(0, 127);
    if (pick < 65)
      return model_base + $urandom_range(0, MEM_SIZE - 1);
    if (pick < 72)
      return model_base - 8 + $urandom_range(0, 16);
    if (pick < 80)
      return model_base + MEM_SIZE - 8 + $urandom_range(0, 16);
    if (pick < 90)
      return resv_addr - 2 + $urandom_range(0, 11);
    return {$urandom, $urandom};
  endfunction

  task automatic test_random_traffic(input logic [ADDR_W-1:0] base, input int count,
                                     input bit gaps);
    logic [1:0]        cmd;
    logic [DATA_W-1:0] data;
    int unsigned       pick;
    int                n;
    write_base(base);
    gaps_enabled = gaps;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        cmd = CMD_LOAD;
      else if (pick < 72)
        cmd = CMD_STORE;
      else if (pick < 88)
        cmd = CMD_RESERVE;
      else
        cmd = CMD_NOP;
      pick = $urandom_range(0, 99);
      if (pick < 10)
        data = ALL_ONES;
      else if (pick < 15)
        data = '0;
      else
        data = {$urandom, $urandom};
      send_access(cmd, pick_address(), 2'($urandom_range(0, 3)), data);
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin
    foreach (mem_image[i]) mem_image[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_sizes();
    test_bounds();
    test_top_of_space();
    test_reservation();
    test_random_traffic({$urandom, $urandom}, 450, 1'b1);
    test_random_traffic('0, 450, 1'b0);
    test_random_traffic(ALL_ONES - MEM_SIZE + 1, 450, 1'b1);
    drain_results();
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bbma_pkg.sv
rtl/bbma_ram.sv
rtl/bbma_bounds.sv
rtl/bounded_byte_memory_access.sv
tb/bounded_byte_memory_access_tb.sv
